@@ rtl/core/scan_result_rssi_table_top_assert.svh @@
// Assertion macros for the scan result table. They expect clk and rst_n in scope.
`ifndef SCAN_RESULT_RSSI_TABLE_TOP_ASSERT_SVH
`define SCAN_RESULT_RSSI_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SRT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scan result table: same-cycle check failed");
// Next-cycle implication.
`define SRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scan result table: next-cycle check failed");
`else
`define SRT_ASSERT_SAME(lbl, ante, cons)
`define SRT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/srt_pkg.sv @@
`default_nettype none
package srt_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int ADDRESS_BYTES = 6;

  localparam int ADDR_W    = 48;
  localparam int STR_W     = 8;
  localparam int CNT_W     = 16;
  localparam int ACT_W     = 2;
  localparam int OUT_IDX_W = 3;
  localparam int SIZE_W    = 4;

  // Only the low ADDRESS_BYTES bytes of an address take part.
  localparam int KEY_W  = (ADDRESS_BYTES * 8 < ADDR_W) ? ADDRESS_BYTES * 8 : ADDR_W;
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

  // Running mean: strength * count + rssi, then divide by count + 1.
  localparam int PROD_W = STR_W + CNT_W + 1;
  localparam int MAG_W  = PROD_W - 1;
  localparam int QUO_W  = STR_W;
  localparam int QCNT_W = $clog2(QUO_W);
  localparam int REM_W  = CNT_W + 1;

  localparam logic signed [STR_W-1:0] STRENGTH_CEILING = {1'b0, {(STR_W-1){1'b1}}};
  localparam logic [CNT_W-1:0]        COUNT_CEILING    = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_AVERAGED = 2'd0,
    ACT_APPENDED = 2'd1,
    ACT_REPLACED = 2'd2,
    ACT_DROPPED  = 2'd3
  } action_t;

  typedef struct packed {
    logic load;
    logic idx_inc;
    logic idx_clear;
    logic mul;
    logic dprep;
    logic dstep;
    logic avg_wr;
    logic append;
    logic weak_step;
    logic replace;
    logic drop;
    logic emit;
  } srt_cmd_t;

  typedef struct packed {
    logic match;
    logic empty;
    logic full;
    logic last_fill;
    logic last_entry;
    logic found;
    logic div_last;
    logic out_free;
  } srt_stat_t;

  function automatic logic [OUT_IDX_W-1:0] idx_out(input logic [IDX_W-1:0] i);
    logic [31:0] w;
    begin
      w = 32'(i);
      return w[OUT_IDX_W-1:0];
    end
  endfunction

  function automatic logic [SIZE_W-1:0] size_out(input logic [FILL_W-1:0] f);
    logic [31:0] w;
    begin
      w = 32'(f);
      return w[SIZE_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/srt_chan_if.sv @@
`default_nettype none
interface srt_in_if;
  logic                             valid;
  logic                             ready;
  logic [srt_pkg::ADDR_W-1:0]       device_address;
  logic signed [srt_pkg::STR_W-1:0] signal_strength;

  modport source (output valid, output device_address, output signal_strength, input ready);
  modport sink   (input valid, input device_address, input signal_strength, output ready);
endinterface

interface srt_out_if;
  logic                                valid;
  logic                                ready;
  logic [srt_pkg::ACT_W-1:0]           action;
  logic [srt_pkg::OUT_IDX_W-1:0]       entry_index;
  logic signed [srt_pkg::STR_W-1:0]    entry_strength;
  logic [srt_pkg::CNT_W-1:0]           entry_count;
  logic [srt_pkg::SIZE_W-1:0]          table_size;

  modport source (output valid, output action, output entry_index, output entry_strength,
                  output entry_count, output table_size, input ready);
  modport sink   (input valid, input action, input entry_index, input entry_strength,
                  input entry_count, input table_size, output ready);
endinterface
`default_nettype wire

@@ rtl/core/scan_result_rssi_table_top.sv @@
`default_nettype none
// Scan result table: keeps up to eight advertisers, each with an averaged RSSI and a
// sighting count. Every word accepted on in_ch yields exactly one word on out_ch that
// says what happened: averaged into a known entry, appended, replaced the weakest
// entry below the new RSSI, or dropped. The block takes one sighting at a time and
// takes the next only once its sequencer is back in idle. An empty table goes straight
// to append and emit; a hit runs multiply, divide and mean write before emit; a miss
// in a full table scans for the weakest entry, then replaces or drops. The scan reads
// one table entry per cycle, and the running mean uses an eight-step restoring divider.
// A result waiting on out_ch lets the next sighting in, but that sighting then holds
// in its emit step until the waiting word leaves. The table starts empty after reset.
`include "scan_result_rssi_table_top_assert.svh"
module scan_result_rssi_table_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  srt_in_if.sink     in_ch,
  srt_out_if.source  out_ch
);
  import srt_pkg::*;

  srt_cmd_t  cmd;
  srt_stat_t st;
  logic      in_rdy;

  // Sequencer: walks match scan, then append, or multiply and divide, or weakest scan, and emit.
  srt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_rdy),
    .st       (st),
    .cmd      (cmd)
  );

  // Table, arithmetic and the output word register.
  srt_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .in_addr      (in_ch.device_address),
    .in_str       (in_ch.signal_strength),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_action   (out_ch.action),
    .out_index    (out_ch.entry_index),
    .out_strength (out_ch.entry_strength),
    .out_count    (out_ch.entry_count),
    .out_size     (out_ch.table_size)
  );

  assign in_ch.ready = in_rdy;

  // Hold off a second sighting while one is in work.
  `SRT_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  // A dropped sighting reports an empty slot.
  `SRT_ASSERT_SAME(a_drop_zero, out_ch.valid && (out_ch.action == ACT_DROPPED),
    (out_ch.entry_count == '0) && (out_ch.entry_index == '0) && (out_ch.entry_strength == '0))
  // Any touched slot holds at least one sighting.
  `SRT_ASSERT_SAME(a_live_count, out_ch.valid && (out_ch.action != ACT_DROPPED),
    out_ch.entry_count != '0)
  // An appended entry starts at one and the table is not empty.
  `SRT_ASSERT_SAME(a_append_one, out_ch.valid && (out_ch.action == ACT_APPENDED),
    (out_ch.entry_count == CNT_W'(1)) && (out_ch.table_size != '0))

endmodule
`default_nettype wire

@@ rtl/core/srt_ctrl.sv @@
`default_nettype none
module srt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire srt_pkg::srt_stat_t st,
  output srt_pkg::srt_cmd_t       cmd
);
  import srt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MATCH, S_MUL, S_DPREP, S_DIV, S_AVG, S_APPEND, S_WEAK, S_DECIDE, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        if (st.empty) begin
          state_nxt = S_APPEND;
        end else if (st.match) begin
          state_nxt = S_MUL;
        end else if (st.last_fill) begin
          if (st.full) begin
            cmd.idx_clear = 1'b1;
            state_nxt     = S_WEAK;
          end else begin
            state_nxt = S_APPEND;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DPREP;
      end
      S_DPREP: begin
        cmd.dprep = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.dstep = 1'b1;
        if (st.div_last) begin
          state_nxt = S_AVG;
        end
      end
      S_AVG: begin
        cmd.avg_wr = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_WEAK: begin
        cmd.weak_step = 1'b1;
        if (st.last_entry) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_DECIDE: begin
        if (st.found) begin
          cmd.replace = 1'b1;
        end else begin
          cmd.drop = 1'b1;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/srt_dp.sv @@
`default_nettype none
module srt_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire srt_pkg::srt_cmd_t                cmd,
  output srt_pkg::srt_stat_t                    st,
  input  wire logic [srt_pkg::ADDR_W-1:0]       in_addr,
  input  wire logic signed [srt_pkg::STR_W-1:0] in_str,
  input  wire logic                             out_ready,
  output logic                                  out_valid,
  output logic [srt_pkg::ACT_W-1:0]             out_action,
  output logic [srt_pkg::OUT_IDX_W-1:0]         out_index,
  output logic signed [srt_pkg::STR_W-1:0]      out_strength,
  output logic [srt_pkg::CNT_W-1:0]             out_count,
  output logic [srt_pkg::SIZE_W-1:0]            out_size
);
  import srt_pkg::*;

  // Table storage, read at the scan pointer only.
  logic [KEY_W-1:0]        key_store_r [TABLE_ENTRIES];
  logic signed [STR_W-1:0] str_store_r [TABLE_ENTRIES];
  logic [CNT_W-1:0]        cnt_store_r [TABLE_ENTRIES];
  logic [FILL_W-1:0]       filled_r;

  logic [KEY_W-1:0]         key_r;
  logic signed [STR_W-1:0]  rssi_r;
  logic [IDX_W-1:0]         idx_r;
  logic [IDX_W-1:0]         slot_r;
  logic signed [STR_W-1:0]  weak_r;
  logic                     found_r;

  logic signed [PROD_W-1:0] sum_r;
  logic [REM_W-1:0]         div_r;
  logic                     neg_r;
  logic [REM_W-1:0]         rem_r;
  logic [QUO_W-1:0]         dvd_r;
  logic [QUO_W-1:0]         q_r;
  logic [QCNT_W-1:0]        qcnt_r;

  logic [ACT_W-1:0]         res_act_r;
  logic [IDX_W-1:0]         res_idx_r;
  logic signed [STR_W-1:0]  res_str_r;
  logic [CNT_W-1:0]         res_cnt_r;

  logic                     out_valid_r;
  logic [ACT_W-1:0]         out_action_r;
  logic [OUT_IDX_W-1:0]     out_index_r;
  logic signed [STR_W-1:0]  out_strength_r;
  logic [CNT_W-1:0]         out_count_r;
  logic [SIZE_W-1:0]        out_size_r;

  logic [KEY_W-1:0]         cur_key;
  logic signed [STR_W-1:0]  cur_str;
  logic [CNT_W-1:0]         cur_cnt;
  logic [IDX_W-1:0]         app_idx;
  logic signed [PROD_W-1:0] mul_w;
  logic signed [PROD_W-1:0] sum_nxt;
  logic signed [PROD_W-1:0] abs_w;
  logic [REM_W:0]           trial_w;
  logic [REM_W:0]           diff_w;
  logic                     ge_w;
  logic [REM_W-1:0]         rem_nxt;
  logic signed [STR_W-1:0]  avg_nxt;
  logic [CNT_W-1:0]         cnt_nxt;
  logic                     weaker_w;

  assign cur_key = key_store_r[idx_r];
  assign cur_str = str_store_r[idx_r];
  assign cur_cnt = cnt_store_r[idx_r];
  assign app_idx = filled_r[IDX_W-1:0];

  assign mul_w   = PROD_W'(cur_str) * PROD_W'($signed({1'b0, cur_cnt}));
  assign sum_nxt = mul_w + PROD_W'(rssi_r);
  assign abs_w   = sum_r[PROD_W-1] ? -sum_r : sum_r;

  // One restoring step: quotient magnitude never exceeds the strength range.
  assign trial_w = {rem_r, dvd_r[QUO_W-1]};
  assign ge_w    = trial_w >= (REM_W+1)'(div_r);
  assign diff_w  = trial_w - (REM_W+1)'(div_r);
  assign rem_nxt = ge_w ? diff_w[REM_W-1:0] : trial_w[REM_W-1:0];

  assign avg_nxt  = neg_r ? $signed(-q_r) : $signed(q_r);
  assign cnt_nxt  = (cur_cnt == COUNT_CEILING) ? cur_cnt : cur_cnt + CNT_W'(1);
  assign weaker_w = (cur_str < weak_r) && (cur_str < rssi_r);

  always_comb begin
    st            = '0;
    st.match      = (cur_key == key_r);
    st.empty      = (filled_r == '0);
    st.full       = (filled_r == FILL_W'(TABLE_ENTRIES));
    st.last_fill  = (FILL_W'(idx_r) == filled_r - FILL_W'(1));
    st.last_entry = (idx_r == IDX_W'(TABLE_ENTRIES - 1));
    st.found      = found_r;
    st.div_last   = (qcnt_r == QCNT_W'(QUO_W - 1));
    st.out_free   = !out_valid_r || out_ready;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.append) begin
        filled_r <= filled_r + FILL_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r   <= in_addr[KEY_W-1:0];
      rssi_r  <= in_str;
      idx_r   <= '0;
      weak_r  <= STRENGTH_CEILING;
      found_r <= 1'b0;
    end
    if (cmd.idx_clear) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + IDX_W'(1);
    end
    if (cmd.weak_step && weaker_w) begin
      weak_r  <= cur_str;
      slot_r  <= idx_r;
      found_r <= 1'b1;
    end
    if (cmd.mul) begin
      sum_r <= sum_nxt;
      div_r <= REM_W'(cur_cnt) + REM_W'(1);
    end
    if (cmd.dprep) begin
      neg_r  <= sum_r[PROD_W-1];
      rem_r  <= REM_W'(abs_w[MAG_W-1:QUO_W]);
      dvd_r  <= abs_w[QUO_W-1:0];
      q_r    <= '0;
      qcnt_r <= '0;
    end
    if (cmd.dstep) begin
      rem_r  <= rem_nxt;
      dvd_r  <= {dvd_r[QUO_W-2:0], 1'b0};
      q_r    <= {q_r[QUO_W-2:0], ge_w};
      qcnt_r <= qcnt_r + QCNT_W'(1);
    end
    if (cmd.avg_wr) begin
      str_store_r[idx_r] <= avg_nxt;
      cnt_store_r[idx_r] <= cnt_nxt;
      res_act_r          <= ACT_AVERAGED;
      res_idx_r          <= idx_r;
      res_str_r          <= avg_nxt;
      res_cnt_r          <= cnt_nxt;
    end
    if (cmd.append) begin
      key_store_r[app_idx] <= key_r;
      str_store_r[app_idx] <= rssi_r;
      cnt_store_r[app_idx] <= CNT_W'(1);
      res_act_r            <= ACT_APPENDED;
      res_idx_r            <= app_idx;
      res_str_r            <= rssi_r;
      res_cnt_r            <= CNT_W'(1);
    end
    if (cmd.replace) begin
      key_store_r[slot_r] <= key_r;
      str_store_r[slot_r] <= rssi_r;
      cnt_store_r[slot_r] <= CNT_W'(1);
      res_act_r           <= ACT_REPLACED;
      res_idx_r           <= slot_r;
      res_str_r           <= rssi_r;
      res_cnt_r           <= CNT_W'(1);
    end
    if (cmd.drop) begin
      res_act_r <= ACT_DROPPED;
      res_idx_r <= '0;
      res_str_r <= '0;
      res_cnt_r <= '0;
    end
    if (cmd.emit) begin
      out_action_r   <= res_act_r;
      out_index_r    <= idx_out(res_idx_r);
      out_strength_r <= res_str_r;
      out_count_r    <= res_cnt_r;
      out_size_r     <= size_out(filled_r);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_action   = out_action_r;
  assign out_index    = out_index_r;
  assign out_strength = out_strength_r;
  assign out_count    = out_count_r;
  assign out_size     = out_size_r;

endmodule
`default_nettype wire
